// ===== rtl/drm_pkg.sv =====
// Shared constants, types and register codes for the divider resistance meter.
`timescale 1ns / 1ps

package drm_pkg;

	// Window depth and field widths
	localparam int unsigned WINDOW    = 10;
	localparam int unsigned SAMPLE_W  = 12;
	localparam int unsigned SUPPLY_W  = 12;
	localparam int unsigned REF_W     = 20;
	localparam int unsigned LIMIT_W   = 24;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned CFG_IDX_W = 2;

	// Stream payload widths, padded to whole bytes
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 24;

	// Derived datapath widths
	localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
	localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned SUM_W  = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);
	localparam int unsigned FULL_W = CNT_W + SUPPLY_W;
	localparam int unsigned NUM_W  = SUM_W + REF_W;
	localparam int unsigned STEP_W = $clog2(NUM_W);

	// Register reset values
	localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 12'd3300;
	localparam logic [REF_W-1:0]    REF_RESET    = 20'd2200;
	localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 24'd1000000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SUPPLY    = 2'd0,
		CFG_REFERENCE = 2'd1,
		CFG_LIMIT     = 2'd2
	} drm_cfg_index_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FULL,
		ST_MUL_NUM,
		ST_DIVIDE,
		ST_DONE
	} drm_state_t;

endpackage

// ===== rtl/divider_resistance_meter_top.sv =====
// Windowed-average divider ohmmeter: window update, shared multiplier, serial divider.
// Flow: an accepted input beat goes through the count*supply and sum*reference multiplies
//   and the 36-step restoring divider (skipped when the divider denominator is not positive).
// Flow control: input is not ready while an item is in work, but a new item is taken while
//   the previous result still waits on the output.
// Reset: arst_n clears control state, window count/sum/slot and loads register defaults;
//   window entries are not cleared and are only read after being written.
`timescale 1ns / 1ps

module divider_resistance_meter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [drm_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] sample_millivolts
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [drm_pkg::M_TDATA_W-1:0] m_tdata,   // [23:0] resistance_ohms
	output logic                          m_tuser,   // [0] over_range
	// configuration write port
	input  logic                          cfg_wr_en,
	input  logic [drm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [drm_pkg::CFG_W-1:0]     cfg_wdata
);
	import drm_pkg::*;

	drm_state_t state_q, state_d;

	logic [SUPPLY_W-1:0] supply_q;
	logic [REF_W-1:0]    ref_q;
	logic [LIMIT_W-1:0]  limit_q;

	logic [SAMPLE_W-1:0] window_q [WINDOW];
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [SUM_W-1:0]    sum_q;

	logic [FULL_W-1:0]   full_q;
	logic [FULL_W-1:0]   den_q;
	logic [FULL_W-1:0]   rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                no_den_q;

	logic                m_tvalid_q;
	logic [LIMIT_W-1:0]  m_tdata_q;
	logic                m_tuser_q;

	logic                s_accept;
	logic                out_free;
	logic [SAMPLE_W-1:0] sample;
	logic                window_full;
	logic [SUM_W-1:0]    sum_next;
	logic [SLOT_W-1:0]   slot_next;
	logic [SUM_W-1:0]    mul_a;
	logic [REF_W-1:0]    mul_b;
	logic [NUM_W-1:0]    mul_p;
	logic                den_le;
	logic [FULL_W:0]     trial;
	logic                trial_ge;
	logic [FULL_W:0]     trial_diff;
	logic                quo_gt;
	logic                quo_eq;
	logic                over;

	// handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign sample   = s_tdata[SAMPLE_W-1:0];

	// window update: add new sample, drop oldest once full
	assign window_full = (fill_q == CNT_W'(WINDOW));
	assign sum_next    = window_full
		? sum_q - SUM_W'(window_q[slot_q]) + SUM_W'(sample)
		: sum_q + SUM_W'(sample);
	assign slot_next   = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

	// shared multiplier: count*supply, then sum*reference
	assign mul_a = (state_q == ST_MUL_FULL) ? SUM_W'(fill_q) : sum_q;
	assign mul_b = (state_q == ST_MUL_FULL) ? REF_W'(supply_q) : ref_q;
	assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);
	assign den_le = (full_q <= FULL_W'(sum_q));

	// one restoring divide step
	assign trial      = {rem_q, quo_q[NUM_W-1]};
	assign trial_ge   = (trial >= {1'b0, den_q});
	assign trial_diff = trial - {1'b0, den_q};

	// exact over-limit test: no positive denominator, quotient above limit, or equal with a remainder
	assign quo_gt = (quo_q > NUM_W'(limit_q));
	assign quo_eq = (quo_q == NUM_W'(limit_q));
	assign over   = no_den_q || quo_gt || (quo_eq && (rem_q != '0));

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= SUPPLY_RESET;
			ref_q    <= REF_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SUPPLY:    supply_q <= cfg_wdata[SUPPLY_W-1:0];
				CFG_REFERENCE: ref_q    <= cfg_wdata[REF_W-1:0];
				CFG_LIMIT:     limit_q  <= cfg_wdata[LIMIT_W-1:0];
				default:       ;
			endcase
		end
	end

	// window storage, written on accept only
	always_ff @(posedge clk) begin
		if (s_accept) begin
			window_q[slot_q] <= sample;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (s_accept) begin
			slot_q <= slot_next;
			sum_q  <= sum_next;
			if (!window_full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_MUL_FULL;
			ST_MUL_FULL: state_d = ST_MUL_NUM;
			ST_MUL_NUM:  state_d = den_le ? ST_DONE : ST_DIVIDE;
			ST_DIVIDE:   if (step_q == '0) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL_FULL: begin
				full_q <= mul_p[FULL_W-1:0];
			end
			ST_MUL_NUM: begin
				quo_q    <= mul_p;
				den_q    <= full_q - FULL_W'(sum_q);
				rem_q    <= '0;
				step_q   <= STEP_W'(NUM_W - 1);
				no_den_q <= den_le;
			end
			ST_DIVIDE: begin
				rem_q  <= trial_ge ? trial_diff[FULL_W-1:0] : trial[FULL_W-1:0];
				quo_q  <= {quo_q[NUM_W-2:0], trial_ge};
				step_q <= step_q - STEP_W'(1);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= over ? '0 : quo_q[LIMIT_W-1:0];
			m_tuser_q <= over;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_tdata_q);
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	// fill count never passes the window depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count above window depth");

	// write slot stays inside the window
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1))
		else $error("write slot out of range");

	// an accepted beat blocks input on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// an over-range result carries zero resistance
	a_over_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("over-range result with nonzero resistance");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the divider resistance meter: directed plan, then random phases.
`timescale 1ns / 1ps

module tb;
	import drm_pkg::*;

	localparam int unsigned SETTLE          = 60;    // extra wait, in cycles, once no reading is pending
	localparam int unsigned PHASES          = 11;
	localparam int unsigned ITEMS_PER_PHASE = 100;
	localparam int unsigned SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // no register behind this index

	typedef struct packed {
		logic [LIMIT_W-1:0] ohms;
		logic               over;
	} reading_t;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] sel;
		logic [CFG_W-1:0]     value;
		logic [SAMPLE_W-1:0]  mv;
		logic                 typed;   // want holds a hand-typed reading
		reading_t             want;
	} plan_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// Mirror of the meter: window, count, sum and registers
	logic [SAMPLE_W-1:0] held [WINDOW];
	int unsigned         next_slot  = 0;
	int unsigned         held_count = 0;
	longint unsigned     held_sum   = 0;
	logic [SUPPLY_W-1:0] supply_mv  = SUPPLY_RESET;
	logic [REF_W-1:0]    ref_ohms   = REF_RESET;
	logic [LIMIT_W-1:0]  limit_ohms = LIMIT_RESET;

	reading_t    expected_readings [$];
	reading_t    oldest;
	int unsigned errors    = 0;
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;

	divider_resistance_meter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),    // [11:0] sample_millivolts
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),    // [23:0] resistance_ohms
		.m_tuser   (m_tuser),    // [0] over_range
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Slide one sample into the window and work out the reading it yields
	function automatic reading_t measure_next(input logic [SAMPLE_W-1:0] mv);
		longint unsigned full;
		longint unsigned den;
		longint unsigned num;
		reading_t        r;
		if (held_count < WINDOW) begin
			held_count++;
		end else begin
			held_sum -= held[next_slot];
		end
		held_sum += mv;
		held[next_slot] = mv;
		next_slot = (next_slot + 1) % WINDOW;
		full = held_count;
		full = full * supply_mv;
		r = '0;
		if (full <= held_sum) begin
			r.over = 1'b1;
		end else begin
			den = full - held_sum;
			num = held_sum * ref_ohms;
			// exact compare: a quotient of limit + 0.5 is already over
			if (num > limit_ohms * den) begin
				r.over = 1'b1;
			end else begin
				r.ohms = LIMIT_W'(num / den);
			end
		end
		return r;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
			input logic [CFG_W-1:0] value);
		plan_row_t row;
		row        = '0;
		row.is_cfg = 1'b1;
		row.sel    = sel;
		row.value  = value;
		return row;
	endfunction

	function automatic plan_row_t mv_row(input logic [SAMPLE_W-1:0] mv, input logic typed,
			input logic [LIMIT_W-1:0] ohms, input logic over);
		plan_row_t row;
		row           = '0;
		row.mv        = mv;
		row.typed     = typed;
		row.want.ohms = ohms;
		row.want.over = over;
		return row;
	endfunction

	// One register write; the caller lowers the enable after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		case (sel)
			CFG_SUPPLY:    supply_mv  = value[SUPPLY_W-1:0];
			CFG_REFERENCE: ref_ohms   = value[REF_W-1:0];
			CFG_LIMIT:     limit_ohms = value[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Offer one sample beat, with random idle cycles ahead of it
	task automatic push_sample(input logic [SAMPLE_W-1:0] mv, input logic typed,
			input reading_t want);
		reading_t r;
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, mv};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		r = measure_next(mv);
		expected_readings.insert(expected_readings.size(), typed ? want : r);
		@(negedge clk);
	endtask

	// Stop sending, wait out every pending reading, then let the block settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_readings.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Receiver backpressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Reading checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				$error("reading with none pending: resistance_ohms %0d over_range %0b",
					m_tdata, m_tuser);
				errors++;
			end else begin
				oldest = expected_readings.pop_front();
				if (m_tdata !== oldest.ohms) begin
					$error("resistance_ohms: expected %0d, got %0d", oldest.ohms, m_tdata);
					errors++;
				end
				if (m_tuser !== oldest.over) begin
					$error("over_range: expected %0b, got %0b", oldest.over, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		plan_row_t   plan [$];
		reading_t    no_reading;
		int unsigned phase;
		int unsigned n;
		int unsigned burst_left;
		int unsigned level;
		int unsigned spread;
		int unsigned lo;
		int unsigned hi;
		int          v;

		no_reading = '0;
		plan = '{
			// half-ohm quotient over a zero limit, with a one-sample window
			cfg_row(CFG_SUPPLY, 24'd3), cfg_row(CFG_REFERENCE, 24'd1),
			cfg_row(CFG_LIMIT, 24'd0),
			mv_row(12'd1, 1'b1, '0, 1'b1),
			cfg_row(CFG_SUPPLY, 24'd3300), cfg_row(CFG_REFERENCE, 24'd2200),
			cfg_row(CFG_LIMIT, 24'd1000000),
			// window fills up
			mv_row(12'd0, 1'b0, '0, 1'b0), mv_row(12'd4095, 1'b0, '0, 1'b0),
			mv_row(12'd1650, 1'b0, '0, 1'b0), mv_row(12'd3300, 1'b0, '0, 1'b0),
			mv_row(12'd1, 1'b0, '0, 1'b0), mv_row(12'd2048, 1'b0, '0, 1'b0),
			mv_row(12'd4095, 1'b0, '0, 1'b0), mv_row(12'd4095, 1'b0, '0, 1'b0),
			mv_row(12'd4095, 1'b0, '0, 1'b0),
			// wrap: oldest samples leave, window ends up all above supply
			mv_row(12'd4095, 1'b0, '0, 1'b0), mv_row(12'd4095, 1'b0, '0, 1'b0),
			mv_row(12'd4095, 1'b0, '0, 1'b0), mv_row(12'd4095, 1'b0, '0, 1'b0),
			mv_row(12'd4095, 1'b0, '0, 1'b0), mv_row(12'd4095, 1'b0, '0, 1'b0),
			mv_row(12'd4095, 1'b1, '0, 1'b1),
			// zero supply: never a positive denominator
			cfg_row(CFG_SUPPLY, 24'd0),
			mv_row(12'd100, 1'b1, '0, 1'b1),
			// zero reference: always zero ohms
			cfg_row(CFG_SUPPLY, 24'd4095), cfg_row(CFG_REFERENCE, 24'd0),
			mv_row(12'd0, 1'b1, '0, 1'b0),
			cfg_row(CFG_REFERENCE, 24'd1000000), cfg_row(CFG_LIMIT, 24'd0),
			mv_row(12'd2000, 1'b0, '0, 1'b0),
			cfg_row(CFG_LIMIT, 24'hFFFFFF),
			mv_row(12'd4094, 1'b0, '0, 1'b0),
			// write to an index with no register is dropped
			cfg_row(CFG_SPARE, 24'hFFFFFF),
			mv_row(12'd1, 1'b0, '0, 1'b0),
			cfg_row(CFG_SUPPLY, 24'd1),
			mv_row(12'd0, 1'b0, '0, 1'b0)
		};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed plan
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_wr_en) drain();
				write_reg(plan[i].sel, plan[i].value);
			end else begin
				if (cfg_wr_en) cfg_wr_en <= 1'b0;
				push_sample(plan[i].mv, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: new settings, new idle pattern, bursts around a level
		for (phase = 0; phase < PHASES; phase++) begin
			drain();
			case ($urandom_range(9))
				0:       write_reg(CFG_SUPPLY, 24'd1);
				1:       write_reg(CFG_SUPPLY, 24'd4095);
				2:       write_reg(CFG_SUPPLY, 24'd0);
				default: write_reg(CFG_SUPPLY, CFG_W'($urandom_range(4095, 1)));
			endcase
			case ($urandom_range(7))
				0:       write_reg(CFG_REFERENCE, 24'd1);
				1:       write_reg(CFG_REFERENCE, 24'd1000000);
				2:       write_reg(CFG_REFERENCE, 24'd0);
				3:       write_reg(CFG_REFERENCE, 24'hFFFFF);
				default: write_reg(CFG_REFERENCE, CFG_W'($urandom_range(1000000, 1)));
			endcase
			case ($urandom_range(7))
				0:       write_reg(CFG_LIMIT, 24'd0);
				1:       write_reg(CFG_LIMIT, 24'hFFFFFF);
				2, 3:    write_reg(CFG_LIMIT, CFG_W'($urandom_range(50000)));
				default: write_reg(CFG_LIMIT, CFG_W'($urandom_range(24'hFFFFFF)));
			endcase
			cfg_wr_en <= 1'b0;
			case (phase % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			burst_left = 0;
			level      = 0;
			spread     = 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(14, 4);
					spread     = $urandom_range(8);
					case ($urandom_range(9))
						// hug the supply so the limit and the sign of den both flip
						0, 1, 2: begin
							lo    = (supply_mv > 24) ? supply_mv - 24 : 0;
							hi    = (supply_mv + 4 > SAMPLE_MAX) ? SAMPLE_MAX : supply_mv + 4;
							level = $urandom_range(hi, lo);
						end
						3: begin
							case ($urandom_range(2))
								0:       level = 0;
								1:       level = SAMPLE_MAX;
								default: level = supply_mv;
							endcase
						end
						default: level = (supply_mv > 1) ? $urandom_range(supply_mv - 1) : 0;
					endcase
				end
				burst_left--;
				if ($urandom_range(99) < 12) begin
					v = int'($urandom_range(SAMPLE_MAX));
				end else begin
					v = int'(level) + int'($urandom_range(2 * spread)) - int'(spread);
					if (v < 0) v = 0;
					if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
				end
				push_sample(SAMPLE_W'(v), 1'b0, no_reading);
			end
		end

		drain();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
